[hw/rtl/ezvs_pkg.sv]
// Shared types, constants and reset values of the energy/crossing voice segmenter.
package ezvs_pkg;

	localparam int MAX_BLOCK    = 4096;
	localparam int MAX_CHANNELS = 2;

	localparam int SAMPLE_W   = 16;
	localparam int MAG_W      = SAMPLE_W + 1;
	localparam int SQ_W       = 2 * SAMPLE_W - 1;
	localparam int ENERGY_W   = 43;
	localparam int COUNT_W    = 13;
	localparam int HOLD_W     = 4;
	localparam int SEG_W      = 16;
	localparam int CHAN_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 43;

	typedef enum logic [2:0] {
		ACT_DISCARD  = 3'd0,
		ACT_HOLD     = 3'd1,
		ACT_REPLACE  = 3'd2,
		ACT_START    = 3'd3,
		ACT_CONTINUE = 3'd4,
		ACT_END      = 3'd5,
		ACT_CANCEL   = 3'd6
	} action_t;

	typedef enum logic {
		ST_SILENT = 1'b0,
		ST_SOUND  = 1'b1
	} state_t;

	typedef enum logic [1:0] {
		SIGN_NONE = 2'd0,
		SIGN_POS  = 2'd1,
		SIGN_NEG  = 2'd2
	} sign_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNEL_COUNT  = 3'd0,
		CFG_BLOCK_LENGTH   = 3'd1,
		CFG_ENERGY_LOW     = 3'd2,
		CFG_ENERGY_HIGH    = 3'd3,
		CFG_CROSSINGS_LOW  = 3'd4,
		CFG_CROSSINGS_HIGH = 3'd5,
		CFG_SILENCE_HOLD   = 3'd6,
		CFG_SEGMENT_MIN    = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [CHAN_W-1:0]   channel_count;
		logic [COUNT_W-1:0]  block_length;
		logic [ENERGY_W-1:0] energy_low;
		logic [ENERGY_W-1:0] energy_high;
		logic [COUNT_W-1:0]  crossings_low;
		logic [COUNT_W-1:0]  crossings_high;
		logic [HOLD_W-1:0]   silence_hold_max;
		logic [SEG_W-1:0]    segment_min_blocks;
	} cfg_t;

	// segment tracking context, updated once per block
	typedef struct packed {
		state_t             st;
		logic [HOLD_W-1:0]  held;
		logic [SEG_W-1:0]   seg_len;
	} seg_ctx_t;

	// per-frame data out of the input stage
	typedef struct packed {
		logic [SQ_W-1:0] sq;
		logic            neg;
		logic            nz;
	} frame_t;

	localparam cfg_t CFG_RESET = '{
		channel_count:      CHAN_W'(2),
		block_length:       COUNT_W'(480),
		energy_low:         ENERGY_W'(1073742),
		energy_high:        ENERGY_W'(10737418),
		crossings_low:      COUNT_W'(144),
		crossings_high:     COUNT_W'(240),
		silence_hold_max:   HOLD_W'(5),
		segment_min_blocks: SEG_W'(20)
	};

endpackage

[hw/rtl/ezvs_frame_sq.sv]
// Input stage: takes a frame item, forms the peak magnitude square and sign.
module ezvs_frame_sq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [ezvs_pkg::SAMPLE_W-1:0] sample_a,
	input  logic signed [ezvs_pkg::SAMPLE_W-1:0] sample_b,
	input  logic                          use_b,
	input  logic                          adv,
	output logic                          valid_s1,
	output ezvs_pkg::frame_t              frame_s1
);
	import ezvs_pkg::*;

	logic [MAG_W-1:0]   mag_a;
	logic [MAG_W-1:0]   mag_b;
	logic [MAG_W-1:0]   peak;
	logic [2*MAG_W-1:0] prod;
	logic               load;

	assign mag_a = sample_a[SAMPLE_W-1] ? (MAG_W'(0) - {sample_a[SAMPLE_W-1], sample_a})
	                                    : {1'b0, sample_a};
	assign mag_b = sample_b[SAMPLE_W-1] ? (MAG_W'(0) - {sample_b[SAMPLE_W-1], sample_b})
	                                    : {1'b0, sample_b};
	assign peak  = (use_b && (mag_b > mag_a)) ? mag_b : mag_a;
	assign prod  = peak * peak;

	assign in_stall = valid_s1 && !adv;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_s1.sq  <= prod[SQ_W-1:0];
			frame_s1.neg <= sample_a[SAMPLE_W-1];
			frame_s1.nz  <= (peak != '0);
		end
	end

endmodule

[hw/rtl/ezvs_decide.sv]
// Block decision: two-threshold silent/sound machine with hangover and minimum length.
module ezvs_decide (
	input  ezvs_pkg::cfg_t                 cfg,
	input  logic [ezvs_pkg::ENERGY_W-1:0]  energy,
	input  logic [ezvs_pkg::COUNT_W-1:0]   crossings,
	input  ezvs_pkg::seg_ctx_t             ctx_cur,
	output ezvs_pkg::seg_ctx_t             ctx_nxt,
	output ezvs_pkg::action_t              action,
	output logic                           flush
);
	import ezvs_pkg::*;

	logic             loud;
	logic             moderate;
	logic             hold_room;
	logic [SEG_W:0]   seg_sum;
	logic [SEG_W-1:0] seg_sat;
	state_t           st_nxt;

	assign loud      = (energy > cfg.energy_high) || (crossings > cfg.crossings_high);
	assign moderate  = (energy > cfg.energy_low) || (crossings > cfg.crossings_low);
	assign hold_room = ctx_cur.held < cfg.silence_hold_max;
	assign seg_sum   = {1'b0, ctx_cur.seg_len} + (SEG_W+1)'(ctx_cur.held) + (SEG_W+1)'(1);
	assign seg_sat   = seg_sum[SEG_W] ? '1 : seg_sum[SEG_W-1:0];

	// next state
	always_comb begin
		unique case (ctx_cur.st)
			ST_SILENT: st_nxt = loud ? ST_SOUND : ST_SILENT;
			ST_SOUND:  st_nxt = (!moderate && !hold_room) ? ST_SILENT : ST_SOUND;
		endcase
	end

	// action and counters
	always_comb begin
		ctx_nxt.st      = st_nxt;
		action          = ACT_DISCARD;
		flush           = 1'b0;
		ctx_nxt.held    = ctx_cur.held;
		ctx_nxt.seg_len = ctx_cur.seg_len;
		unique case (ctx_cur.st)
			ST_SILENT: begin
				if (loud) begin
					action          = ACT_START;
					flush           = (ctx_cur.held != '0);
					ctx_nxt.seg_len = SEG_W'(ctx_cur.held) + SEG_W'(1);
					ctx_nxt.held    = '0;
				end else if (moderate) begin
					if (hold_room) begin
						action       = ACT_HOLD;
						ctx_nxt.held = ctx_cur.held + HOLD_W'(1);
					end else begin
						action = ACT_REPLACE;
					end
				end else begin
					action       = ACT_DISCARD;
					ctx_nxt.held = '0;
				end
			end
			ST_SOUND: begin
				if (moderate) begin
					action          = ACT_CONTINUE;
					flush           = (ctx_cur.held != '0);
					ctx_nxt.seg_len = seg_sat;
					ctx_nxt.held    = '0;
				end else if (hold_room) begin
					action       = ACT_HOLD;
					ctx_nxt.held = ctx_cur.held + HOLD_W'(1);
				end else begin
					action          = (ctx_cur.seg_len >= cfg.segment_min_blocks) ? ACT_END
					                                                              : ACT_CANCEL;
					ctx_nxt.seg_len = '0;
					ctx_nxt.held    = '0;
				end
			end
		endcase
	end

endmodule

[hw/rtl/energy_zcr_voice_segmenter_top.sv]
// Top level: config registers, block accumulators, segment context and result register.
// A block's result passes through the input stage register, then the result register.
// Throughput: one frame item per cycle; the input stage squares, the second stage
// does the 43-bit accumulate, threshold compares and decision into the result register.
// A stalled result holds the second stage only on a block's last frame.
// Reset (arst_n low, asynchronous): accumulators, context and valids cleared, config
// registers back to defaults; no clearing pass.
module energy_zcr_voice_segmenter_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [ezvs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ezvs_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [ezvs_pkg::SAMPLE_W-1:0] sample_a,
	input  logic signed [ezvs_pkg::SAMPLE_W-1:0] sample_b,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [2:0]                           action,
	output logic                                 flush_held,
	output logic [ezvs_pkg::ENERGY_W-1:0]        block_energy,
	output logic [ezvs_pkg::COUNT_W-1:0]         block_crossings,
	output logic                                 in_sound,
	output logic [ezvs_pkg::SEG_W-1:0]           segment_blocks
);
	import ezvs_pkg::*;

	cfg_t                cfg_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [COUNT_W-1:0]  count_q;
	sign_t               last_sign_q;
	logic [COUNT_W-1:0]  frame_q;
	seg_ctx_t            ctx_q;

	logic                valid_s1;
	frame_t              frame_s1;
	logic                use_b;
	logic                adv;
	logic                out_free;
	logic                blk_end;

	logic [COUNT_W-1:0]  len_eff;
	logic [COUNT_W-1:0]  frame_nxt;
	logic [ENERGY_W:0]   sum_ext;
	logic [ENERGY_W-1:0] energy_new;
	logic [COUNT_W-1:0]  count_new;
	sign_t               sign_cur;

	seg_ctx_t            ctx_nxt;
	action_t             dec_action;
	logic                dec_flush;

	action_t             out_action_q;
	logic                out_valid_q;
	logic                out_flush_q;
	logic [ENERGY_W-1:0] out_energy_q;
	logic [COUNT_W-1:0]  out_cross_q;
	logic                out_sound_q;
	logic [SEG_W-1:0]    out_seg_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CHANNEL_COUNT:  cfg_q.channel_count      <= cfg_data[CHAN_W-1:0];
				CFG_BLOCK_LENGTH:   cfg_q.block_length       <= cfg_data[COUNT_W-1:0];
				CFG_ENERGY_LOW:     cfg_q.energy_low         <= cfg_data[ENERGY_W-1:0];
				CFG_ENERGY_HIGH:    cfg_q.energy_high        <= cfg_data[ENERGY_W-1:0];
				CFG_CROSSINGS_LOW:  cfg_q.crossings_low      <= cfg_data[COUNT_W-1:0];
				CFG_CROSSINGS_HIGH: cfg_q.crossings_high     <= cfg_data[COUNT_W-1:0];
				CFG_SILENCE_HOLD:   cfg_q.silence_hold_max   <= cfg_data[HOLD_W-1:0];
				CFG_SEGMENT_MIN:    cfg_q.segment_min_blocks <= cfg_data[SEG_W-1:0];
			endcase
		end
	end

	// zero and three channel codes fold to one and two
	assign use_b = (cfg_q.channel_count >= CHAN_W'(2)) && (MAX_CHANNELS >= 2);

	ezvs_frame_sq u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample_a (sample_a),
		.sample_b (sample_b),
		.use_b    (use_b),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.frame_s1 (frame_s1)
	);

	always_comb begin
		if (cfg_q.block_length == '0) begin
			len_eff = COUNT_W'(1);
		end else if ((COUNT_W+18)'(cfg_q.block_length) > (COUNT_W+18)'(MAX_BLOCK)) begin
			len_eff = COUNT_W'(MAX_BLOCK);
		end else begin
			len_eff = cfg_q.block_length;
		end
	end

	assign frame_nxt  = frame_q + COUNT_W'(1);
	assign blk_end    = (frame_nxt >= len_eff);
	assign out_free   = !out_valid_q || !out_stall;
	assign adv        = valid_s1 && (!blk_end || out_free);

	assign sum_ext    = {1'b0, energy_q} + (ENERGY_W+1)'(frame_s1.sq);
	assign energy_new = sum_ext[ENERGY_W] ? '1 : sum_ext[ENERGY_W-1:0];
	assign sign_cur   = frame_s1.neg ? SIGN_NEG : SIGN_POS;
	assign count_new  = (frame_s1.nz && (sign_cur != last_sign_q) && (count_q != '1))
	                    ? count_q + COUNT_W'(1) : count_q;

	ezvs_decide u_decide (
		.cfg       (cfg_q),
		.energy    (energy_new),
		.crossings (count_new),
		.ctx_cur   (ctx_q),
		.ctx_nxt   (ctx_nxt),
		.action    (dec_action),
		.flush     (dec_flush)
	);

	// block accumulators and segment context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q    <= '0;
			count_q     <= '0;
			last_sign_q <= SIGN_NONE;
			frame_q     <= '0;
			ctx_q       <= '{st: ST_SILENT, held: '0, seg_len: '0};
		end else if (adv) begin
			if (blk_end) begin
				energy_q    <= '0;
				count_q     <= '0;
				last_sign_q <= SIGN_NONE;
				frame_q     <= '0;
				ctx_q       <= ctx_nxt;
			end else begin
				energy_q <= energy_new;
				count_q  <= count_new;
				frame_q  <= frame_nxt;
				if (frame_s1.nz) begin
					last_sign_q <= sign_cur;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && blk_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && blk_end) begin
			out_action_q <= dec_action;
			out_flush_q  <= dec_flush;
			out_energy_q <= energy_new;
			out_cross_q  <= count_new;
			out_sound_q  <= (ctx_nxt.st == ST_SOUND);
			out_seg_q    <= ctx_nxt.seg_len;
		end
	end

	assign out_valid       = out_valid_q;
	assign action          = out_action_q;
	assign flush_held      = out_flush_q;
	assign block_energy    = out_energy_q;
	assign block_crossings = out_cross_q;
	assign in_sound        = out_sound_q;
	assign segment_blocks  = out_seg_q;

`ifndef SYNTHESIS
	a_silent_no_segment: assert property (@(posedge clk) disable iff (!arst_n)
		(ctx_q.st == ST_SILENT) |-> (ctx_q.seg_len == '0))
		else $error("segment length nonzero while silent");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_seg_q)
		&& $stable(out_energy_q)))
		else $error("stalled result lost or changed");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && blk_end && out_valid_q && out_stall))
		else $error("input stalled without a blocked block end");

	a_sound_actions: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_action_q == ACT_START || out_action_q == ACT_CONTINUE))
		|-> (out_sound_q && out_seg_q != '0))
		else $error("start or continue without sound state");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_action_q == ACT_END || out_action_q == ACT_CANCEL))
		|-> (!out_sound_q && out_seg_q == '0 && !out_flush_q))
		else $error("end or cancel left segment state");
`endif

endmodule
